FILE: rtl/core/imufp_pkg.sv
// Package for the IMU frame parser: parse phases, protocol bytes and the
// frame result type shared by the core, the result register and the top level.
// No dependencies.
`default_nettype none

package imufp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned NUM_AXES = 3;

    localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h59;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h53;
    localparam logic [BYTE_W-1:0] REC_ACCEL  = 8'h10;
    localparam logic [BYTE_W-1:0] REC_EULER  = 8'h40;
    localparam logic [BYTE_W-1:0] REC_LEN    = 8'd12;

    // Record byte counter: 0 waits for an id, 1 for a length, 2..13 data bytes.
    localparam logic [3:0] RBC_WAIT_ID  = 4'd0;
    localparam logic [3:0] RBC_WAIT_LEN = 4'd1;
    localparam logic [3:0] RBC_DATA0    = 4'd2;
    localparam logic [3:0] RBC_LAST     = 4'd13;

    typedef enum logic [2:0] {
        PH_HUNT1   = 3'd0,
        PH_HUNT2   = 3'd1,
        PH_ID0     = 3'd2,
        PH_ID1     = 3'd3,
        PH_LEN     = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CKLO    = 3'd6,
        PH_CKHI    = 3'd7
    } t_phase;

    typedef struct packed {
        logic               status;
        logic               accel_upd;
        logic [VALUE_W-1:0] accel_x;
        logic [VALUE_W-1:0] accel_y;
        logic [VALUE_W-1:0] accel_z;
        logic               angles_upd;
        logic [VALUE_W-1:0] pitch;
        logic [VALUE_W-1:0] roll;
        logic [VALUE_W-1:0] yaw;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/imufp_in_reg.sv
// Input register of the IMU frame parser: holds one received byte until the
// parse core consumes it. Uses imufp_pkg for the byte width.
`default_nettype none

module imufp_in_reg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic [imufp_pkg::BYTE_W-1:0] i_byte,
    output logic                             o_stall,
    output logic                             o_valid,
    output logic [imufp_pkg::BYTE_W-1:0]      o_byte,
    input  wire logic                        i_pop
);
    import imufp_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    // Hold a byte the core cannot take yet; otherwise refill every cycle.
    assign o_stall = r_valid && !i_pop;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/imufp_core.sv
// Parse core of the IMU frame parser: header hunt, mod-256 Fletcher sums, record
// decode and pending values; one byte per step. Uses imufp_pkg.
`default_nettype none

module imufp_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_step,
    input  wire logic [imufp_pkg::BYTE_W-1:0] i_byte,
    output logic                              o_at_result,
    output imufp_pkg::t_result                o_result
);
    import imufp_pkg::*;

    t_phase             r_phase,     n_phase;
    logic [BYTE_W-1:0]  r_sum_a,     n_sum_a;
    logic [BYTE_W-1:0]  r_sum_b,     n_sum_b;
    logic [BYTE_W-1:0]  r_left,      n_left;
    logic [BYTE_W-1:0]  r_cand,      n_cand;
    logic [3:0]         r_rbc,       n_rbc;
    logic [VALUE_W-1:0] r_shift,     n_shift;
    logic [VALUE_W-1:0] r_accel  [NUM_AXES];
    logic [VALUE_W-1:0] n_accel  [NUM_AXES];
    logic [VALUE_W-1:0] r_angles [NUM_AXES];
    logic [VALUE_W-1:0] n_angles [NUM_AXES];
    logic [1:0]         r_flags,     n_flags;
    logic [BYTE_W-1:0]  r_check_low, n_check_low;

    logic [BYTE_W-1:0]  sum_a_add;
    logic [BYTE_W-1:0]  sum_b_add;
    logic [BYTE_W-1:0]  left_dec;
    logic [VALUE_W-1:0] shift_in;
    logic [3:0]         data_idx;
    logic [1:0]         axis;
    logic               cand_known;
    logic               ok;
    logic               acc;
    logic               ang;

    assign sum_a_add  = r_sum_a + i_byte;
    assign sum_b_add  = r_sum_b + sum_a_add;
    assign left_dec   = r_left - 8'd1;
    assign shift_in   = {i_byte, r_shift[VALUE_W-1:BYTE_W]};
    assign data_idx   = r_rbc - RBC_DATA0;
    assign axis       = data_idx[3:2];
    assign cand_known = (r_cand == REC_ACCEL) || (r_cand == REC_EULER);

    always_comb begin
        n_phase     = r_phase;
        n_sum_a     = r_sum_a;
        n_sum_b     = r_sum_b;
        n_left      = r_left;
        n_cand      = r_cand;
        n_rbc       = r_rbc;
        n_shift     = r_shift;
        n_accel     = r_accel;
        n_angles    = r_angles;
        n_flags     = r_flags;
        n_check_low = r_check_low;

        unique case (r_phase)
            PH_HUNT1: begin
                if (i_byte == HDR_FIRST) begin
                    n_phase = PH_HUNT2;
                end
            end
            PH_HUNT2: begin
                if (i_byte == HDR_SECOND) begin
                    n_phase = PH_ID0;
                    n_sum_a = '0;
                    n_sum_b = '0;
                    n_flags = '0;
                end else if (i_byte != HDR_FIRST) begin
                    n_phase = PH_HUNT1;
                end
            end
            PH_ID0: begin
                n_sum_a = sum_a_add;
                n_sum_b = sum_b_add;
                n_phase = PH_ID1;
            end
            PH_ID1: begin
                n_sum_a = sum_a_add;
                n_sum_b = sum_b_add;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_sum_a = sum_a_add;
                n_sum_b = sum_b_add;
                n_left  = i_byte;
                n_rbc   = RBC_WAIT_ID;
                n_phase = (i_byte == '0) ? PH_CKLO : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_sum_a = sum_a_add;
                n_sum_b = sum_b_add;
                n_left  = left_dec;
                if (r_rbc == RBC_WAIT_ID) begin
                    n_cand = i_byte;
                    n_rbc  = RBC_WAIT_LEN;
                end else if (r_rbc == RBC_WAIT_LEN) begin
                    // Accept a record only if it fits in what is left.
                    if (cand_known && i_byte == REC_LEN && left_dec >= REC_LEN) begin
                        n_rbc   = RBC_DATA0;
                        n_shift = '0;
                    end else begin
                        n_cand = i_byte;
                        n_rbc  = RBC_WAIT_LEN;
                    end
                end else begin
                    n_shift = shift_in;
                    if (data_idx[1:0] == 2'b11 && axis < 2'(NUM_AXES)) begin
                        if (r_cand == REC_ACCEL) begin
                            n_accel[axis] = shift_in;
                        end else begin
                            n_angles[axis] = shift_in;
                        end
                    end
                    if (r_rbc >= RBC_LAST) begin
                        n_flags = r_flags | ((r_cand == REC_ACCEL) ? 2'b01 : 2'b10);
                        n_rbc   = RBC_WAIT_ID;
                    end else begin
                        n_rbc = r_rbc + 4'd1;
                    end
                end
                if (left_dec == '0) begin
                    n_phase = PH_CKLO;
                end
            end
            PH_CKLO: begin
                n_check_low = i_byte;
                n_phase     = PH_CKHI;
            end
            PH_CKHI: begin
                n_flags = '0;
                n_rbc   = RBC_WAIT_ID;
                n_left  = '0;
                n_phase = PH_HUNT1;
            end
        endcase
    end

    // Frame result, meaningful while the high check byte is in front.
    assign ok  = (r_check_low == r_sum_a) && (i_byte == r_sum_b);
    assign acc = ok && r_flags[0];
    assign ang = ok && r_flags[1];

    assign o_at_result         = (r_phase == PH_CKHI);
    assign o_result.status     = !ok;
    assign o_result.accel_upd  = acc;
    assign o_result.accel_x    = acc ? r_accel[0] : '0;
    assign o_result.accel_y    = acc ? r_accel[1] : '0;
    assign o_result.accel_z    = acc ? r_accel[2] : '0;
    assign o_result.angles_upd = ang;
    assign o_result.pitch      = ang ? r_angles[0] : '0;
    assign o_result.roll       = ang ? r_angles[1] : '0;
    assign o_result.yaw        = ang ? r_angles[2] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
            r_flags <= '0;
            r_rbc   <= RBC_WAIT_ID;
            r_left  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_flags <= n_flags;
            r_rbc   <= n_rbc;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_sum_a     <= n_sum_a;
            r_sum_b     <= n_sum_b;
            r_cand      <= n_cand;
            r_shift     <= n_shift;
            r_accel     <= n_accel;
            r_angles    <= n_angles;
            r_check_low <= n_check_low;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/imufp_out_reg.sv
// Result register of the IMU frame parser: holds one frame result until the
// downstream side takes it. Uses imufp_pkg for the result type.
`default_nettype none

module imufp_out_reg (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire imufp_pkg::t_result  i_result,
    output logic                     o_ready,
    output logic                     o_valid,
    output imufp_pkg::t_result       o_result,
    input  wire logic                i_stall
);
    import imufp_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Take a new result when empty or when the held one leaves this cycle.
    assign o_ready  = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/imu_frame_parser_unit.sv
// IMU binary frame parser, top level: byte input register, parse core and
// frame result register. Depends on imufp_pkg, imufp_in_reg, imufp_core, imufp_out_reg.
`default_nettype none

// Feed the received serial stream one byte per request on i_rx_byte. The block
// hunts for the header 0x59 0x53, reads a two-byte frame id, a length byte,
// the payload and two mod-256 Fletcher check bytes (low byte first); the sums cover
// id, length and payload. Acceleration (0x10) and Euler angle (0x40) records
// of length 12 in the payload are decoded as three little-endian signed
// 32-bit raw values each. One result request leaves per frame, on the high
// check byte: o_frame_status 0 means the frame checked out, 1 a checksum
// mismatch (then all flags and values are 0); values whose updated flag is 0
// read as 0. Every other byte produces no result. The block takes one byte
// per clock cycle while o_stall is low; a byte is held in the input register
// until the parse core consumes it, and a frame result is loaded into the result
// register on the same edge that consumes its high check byte, so o_valid
// rises in the cycle after that byte is consumed. Only a result register held
// by o_valid with i_stall high slows input, and then only once the next high
// check byte reaches the parse core.

module imu_frame_parser_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // byte input channel
    input  wire logic                          i_valid,
    input  wire logic [imufp_pkg::BYTE_W-1:0]  i_rx_byte,
    output logic                               o_stall,
    // frame result channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_frame_status,
    output logic                               o_accel_updated,
    output logic signed [imufp_pkg::VALUE_W-1:0] o_accel_x,
    output logic signed [imufp_pkg::VALUE_W-1:0] o_accel_y,
    output logic signed [imufp_pkg::VALUE_W-1:0] o_accel_z,
    output logic                               o_angles_updated,
    output logic signed [imufp_pkg::VALUE_W-1:0] o_pitch,
    output logic signed [imufp_pkg::VALUE_W-1:0] o_roll,
    output logic signed [imufp_pkg::VALUE_W-1:0] o_yaw
);
    import imufp_pkg::*;

    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              step;
    logic              at_result;
    logic              out_ready;
    t_result           core_result;
    t_result           out_result;

    // Advance the core unless its byte yields a result the output cannot take.
    assign step = in_valid && (!at_result || out_ready);

    imufp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_byte  (i_rx_byte),
        .o_stall (o_stall),
        .o_valid (in_valid),
        .o_byte  (in_byte),
        .i_pop   (step)
    );

    imufp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (in_byte),
        .o_at_result (at_result),
        .o_result    (core_result)
    );

    imufp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step && at_result),
        .i_result (core_result),
        .o_ready  (out_ready),
        .o_valid  (o_valid),
        .o_result (out_result),
        .i_stall  (i_stall)
    );

    // Drive the result fields from the held result.
    assign o_frame_status   = out_result.status;
    assign o_accel_updated  = out_result.accel_upd;
    assign o_accel_x        = $signed(out_result.accel_x);
    assign o_accel_y        = $signed(out_result.accel_y);
    assign o_accel_z        = $signed(out_result.accel_z);
    assign o_angles_updated = out_result.angles_upd;
    assign o_pitch          = $signed(out_result.pitch);
    assign o_roll           = $signed(out_result.roll);
    assign o_yaw            = $signed(out_result.yaw);

endmodule

`default_nettype wire

FILE: sim/imu_frame_parser_unit_tb.sv
// Self-checking testbench for imu_frame_parser_unit: a byte stream of well-formed
// and broken IMU frames, checked against a cycle-free parser model kept here.
// Depends on imufp_pkg and the RTL of imu_frame_parser_unit.
`timescale 1ns / 1ps

module imu_frame_parser_unit_tb;

    import imufp_pkg::*;

    localparam int QUIET_LIMIT   = 5000;  // cycles with no request moved on either side
    localparam int DRAIN_CYCLES  = 20;    // settle time after the last result
    localparam int PHASE_BYTES   = 320;   // minimum random bytes per phase

    // Bit positions in the pending-record flags
    localparam int FLAG_ACCEL  = 0;
    localparam int FLAG_ANGLES = 1;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_CK_ERR = 1'b1;

    // How the check bytes of a generated frame are spoiled
    typedef enum logic [1:0] {
        CK_GOOD,
        CK_BAD_LO,
        CK_BAD_HI
    } t_ck_mode;

    logic                        i_clk   = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic [BYTE_W-1:0]           i_rx_byte = '0;
    logic                        o_stall;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic                        o_frame_status;
    logic                        o_accel_updated;
    logic signed [VALUE_W-1:0]   o_accel_x;
    logic signed [VALUE_W-1:0]   o_accel_y;
    logic signed [VALUE_W-1:0]   o_accel_z;
    logic                        o_angles_updated;
    logic signed [VALUE_W-1:0]   o_pitch;
    logic signed [VALUE_W-1:0]   o_roll;
    logic signed [VALUE_W-1:0]   o_yaw;

    imu_frame_parser_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_rx_byte        (i_rx_byte),
        .o_stall          (o_stall),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_frame_status   (o_frame_status),
        .o_accel_updated  (o_accel_updated),
        .o_accel_x        (o_accel_x),
        .o_accel_y        (o_accel_y),
        .o_accel_z        (o_accel_z),
        .o_angles_updated (o_angles_updated),
        .o_pitch          (o_pitch),
        .o_roll           (o_roll),
        .o_yaw            (o_yaw)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus store, expected frame results and run bookkeeping
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] rx_stream[$];    // bytes waiting to be sent
    logic [BYTE_W-1:0] frame_body[$];   // payload under construction
    t_result           frames_due[$];   // frame results not yet seen
    int                fault_count   = 0;
    int                rx_gap_pct    = 0;   // chance the sender holds off a request
    int                res_hold_pct  = 0;   // chance the receiver stalls
    int                quiet_cycles  = 0;
    logic [7:0]        gen_sum_a, gen_sum_b;

    // ------------------------------------------------------------------
    // Parser model state
    // ------------------------------------------------------------------
    t_phase            mdl_phase = PH_HUNT1;
    logic [7:0]        mdl_sum_a = '0;
    logic [7:0]        mdl_sum_b = '0;
    logic [7:0]        mdl_left  = '0;     // payload bytes still to come
    logic [7:0]        mdl_cand  = '0;     // candidate record id
    logic [3:0]        mdl_rcnt  = '0;     // position inside the current record
    logic [31:0]       mdl_shift = '0;     // little-endian value assembly
    logic [31:0]       mdl_accel[3]  = '{default: '0};
    logic [31:0]       mdl_angles[3] = '{default: '0};
    logic [1:0]        mdl_flags = '0;
    logic [7:0]        mdl_ck_lo = '0;

    task automatic flag_error(input string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        fault_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%s got 0x%08h, expected 0x%08h", name, got, want));
    endtask

    task automatic fold_checksum(input logic [7:0] b);
        mdl_sum_a = mdl_sum_a + b;
        mdl_sum_b = mdl_sum_b + mdl_sum_a;
    endtask

    // Record layer of the payload: id, length 12, then three 32-bit LE values.
    // Anything that is not a usable record start slides the window by one byte.
    task automatic track_record(input logic [7:0] b);
        logic [3:0] pos;
        if (mdl_rcnt == RBC_WAIT_ID) begin
            mdl_cand = b;
            mdl_rcnt = RBC_WAIT_LEN;
        end else if (mdl_rcnt == RBC_WAIT_LEN) begin
            // a record must fit in what is left of the payload
            if ((mdl_cand == REC_ACCEL || mdl_cand == REC_EULER) &&
                b == REC_LEN && mdl_left >= REC_LEN) begin
                mdl_rcnt  = RBC_DATA0;
                mdl_shift = '0;
            end else begin
                mdl_cand = b;
            end
        end else begin
            mdl_shift = {b, mdl_shift[31:8]};
            pos = mdl_rcnt - RBC_DATA0;
            if (pos[1:0] == 2'b11 && pos[3:2] != 2'b11) begin
                if (mdl_cand == REC_ACCEL)
                    mdl_accel[pos[3:2]] = mdl_shift;
                else
                    mdl_angles[pos[3:2]] = mdl_shift;
            end
            if (mdl_rcnt >= RBC_LAST) begin
                if (mdl_cand == REC_ACCEL)
                    mdl_flags[FLAG_ACCEL] = 1'b1;
                else
                    mdl_flags[FLAG_ANGLES] = 1'b1;
                mdl_rcnt = RBC_WAIT_ID;
            end else begin
                mdl_rcnt = mdl_rcnt + 4'd1;
            end
        end
    endtask

    // Advance the model by one received byte; queue a frame result on the
    // high check byte.
    task automatic parse_rx_byte(input logic [7:0] b);
        t_result res;
        logic    ok;
        case (mdl_phase)
            PH_HUNT1: begin
                if (b == HDR_FIRST)
                    mdl_phase = PH_HUNT2;
            end
            PH_HUNT2: begin
                if (b == HDR_SECOND) begin
                    mdl_phase = PH_ID0;
                    mdl_sum_a = '0;
                    mdl_sum_b = '0;
                    mdl_flags = '0;
                end else if (b != HDR_FIRST) begin
                    mdl_phase = PH_HUNT1;
                end
            end
            PH_ID0: begin
                fold_checksum(b);
                mdl_phase = PH_ID1;
            end
            PH_ID1: begin
                fold_checksum(b);
                mdl_phase = PH_LEN;
            end
            PH_LEN: begin
                fold_checksum(b);
                mdl_left = b;
                mdl_rcnt = RBC_WAIT_ID;
                if (b == 8'd0)
                    mdl_phase = PH_CKLO;
                else
                    mdl_phase = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                fold_checksum(b);
                mdl_left = mdl_left - 8'd1;
                track_record(b);
                if (mdl_left == 8'd0)
                    mdl_phase = PH_CKLO;
            end
            PH_CKLO: begin
                mdl_ck_lo = b;
                mdl_phase = PH_CKHI;
            end
            default: begin
                ok = (mdl_ck_lo == mdl_sum_a) && (b == mdl_sum_b);
                res.status     = ok ? STATUS_OK : STATUS_CK_ERR;
                res.accel_upd  = ok && mdl_flags[FLAG_ACCEL];
                res.angles_upd = ok && mdl_flags[FLAG_ANGLES];
                res.accel_x    = res.accel_upd  ? mdl_accel[0]  : '0;
                res.accel_y    = res.accel_upd  ? mdl_accel[1]  : '0;
                res.accel_z    = res.accel_upd  ? mdl_accel[2]  : '0;
                res.pitch      = res.angles_upd ? mdl_angles[0] : '0;
                res.roll       = res.angles_upd ? mdl_angles[1] : '0;
                res.yaw        = res.angles_upd ? mdl_angles[2] : '0;
                frames_due.push_back(res);
                mdl_flags = '0;
                mdl_rcnt  = RBC_WAIT_ID;
                mdl_left  = '0;
                mdl_phase = PH_HUNT1;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Frame generation
    // ------------------------------------------------------------------
    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic add_record(input logic [7:0] rid, input logic [31:0] v0,
                              input logic [31:0] v1, input logic [31:0] v2);
        logic [31:0] vals[3];
        vals = '{v0, v1, v2};
        frame_body.push_back(rid);
        frame_body.push_back(REC_LEN);
        foreach (vals[k])
            for (int n = 0; n < 4; n++)
                frame_body.push_back(vals[k][8*n +: 8]);
    endtask

    task automatic push_random_body(input int count);
        repeat (count) frame_body.push_back(8'($urandom_range(255)));
    endtask

    task automatic emit_summed(input logic [7:0] b);
        rx_stream.push_back(b);
        gen_sum_a = gen_sum_a + b;
        gen_sum_b = gen_sum_b + gen_sum_a;
    endtask

    // Wrap frame_body into a frame, append it to the stream, clear the body.
    task automatic send_frame(input logic [15:0] fid, input t_ck_mode mode);
        logic [7:0] lo, hi;
        gen_sum_a = '0;
        gen_sum_b = '0;
        rx_stream.push_back(HDR_FIRST);
        rx_stream.push_back(HDR_SECOND);
        emit_summed(fid[7:0]);
        emit_summed(fid[15:8]);
        emit_summed(8'(frame_body.size()));
        foreach (frame_body[k])
            emit_summed(frame_body[k]);
        lo = gen_sum_a;
        hi = gen_sum_b;
        if (mode == CK_BAD_LO)
            lo = lo ^ 8'($urandom_range(255, 1));
        if (mode == CK_BAD_HI)
            hi = hi ^ 8'($urandom_range(255, 1));
        rx_stream.push_back(lo);
        rx_stream.push_back(hi);
        frame_body.delete();
    endtask

    // Mostly well-formed frames with random records; some near-miss record
    // starts, records cut by the payload end, and spoiled checksums.
    task automatic send_random_frame();
        int         target;
        int         room;
        logic [7:0] rid;
        t_ck_mode   mode;
        if ($urandom_range(15) == 0)
            target = 0;
        else if ($urandom_range(39) == 0)
            target = 255;
        else
            target = $urandom_range(40, 1);
        while (frame_body.size() < target) begin
            room = target - frame_body.size();
            rid  = $urandom_range(1) ? REC_ACCEL : REC_EULER;
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    if (room >= 14)
                        add_record(rid, pick_value(), pick_value(), pick_value());
                    else
                        push_random_body(1);
                end
                4: begin
                    // right id, arbitrary length byte
                    frame_body.push_back(rid);
                    push_random_body(room >= 2 ? 1 : 0);
                end
                5: begin
                    // record header that runs past the payload end
                    if (room >= 2 && room < 14) begin
                        frame_body.push_back(rid);
                        frame_body.push_back(REC_LEN);
                        push_random_body(room - 2);
                    end else begin
                        push_random_body(1);
                    end
                end
                default: push_random_body(1);
            endcase
        end
        case ($urandom_range(19))
            0:       mode = CK_BAD_LO;
            1:       mode = CK_BAD_HI;
            default: mode = CK_GOOD;
        endcase
        send_frame(16'($urandom()), mode);

        // line noise between frames
        case ($urandom_range(7))
            0: repeat ($urandom_range(3, 1)) rx_stream.push_back(8'($urandom_range(255)));
            1: rx_stream.push_back(HDR_FIRST);
            2: begin
                rx_stream.push_back(HDR_FIRST);
                rx_stream.push_back(8'h00);
            end
            default: ;
        endcase
    endtask

    task automatic send_directed_frames();
        // stray bytes and a broken header before any frame
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'hFF);
        rx_stream.push_back(HDR_SECOND);
        rx_stream.push_back(HDR_FIRST);
        rx_stream.push_back(8'h00);

        // repeated first header byte, zero-length payload
        rx_stream.push_back(HDR_FIRST);
        send_frame(16'h0000, CK_GOOD);

        // acceleration at the value extremes
        add_record(REC_ACCEL, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_frame(16'hFFFF, CK_GOOD);

        // both records in one frame
        add_record(REC_EULER, 32'h0000_0000, 32'h0000_0001, 32'h8000_0000);
        add_record(REC_ACCEL, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F);
        send_frame(16'h5AA5, CK_GOOD);

        // angle record cut short by the payload end
        frame_body.push_back(REC_EULER);
        frame_body.push_back(REC_LEN);
        push_random_body(11);
        send_frame(16'h0102, CK_GOOD);

        // same record twice: the later one holds
        add_record(REC_ACCEL, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333);
        add_record(REC_ACCEL, 32'hCCCC_CCCC, 32'hDDDD_DDDD, 32'hEEEE_EEEE);
        send_frame(16'h8001, CK_GOOD);

        // skipped starts: a lone accel id, then a wrong length
        frame_body.push_back(REC_ACCEL);
        add_record(REC_EULER, pick_value(), pick_value(), pick_value());
        frame_body.push_back(REC_ACCEL);
        frame_body.push_back(8'd13);
        send_frame(16'h4010, CK_GOOD);

        // checksum mismatches drop the decoded values
        add_record(REC_ACCEL, pick_value(), pick_value(), pick_value());
        send_frame(16'h7E7E, CK_BAD_LO);
        add_record(REC_EULER, pick_value(), pick_value(), pick_value());
        send_frame(16'h8181, CK_BAD_HI);

        // longest payload
        add_record(REC_ACCEL, pick_value(), pick_value(), pick_value());
        push_random_body(255 - 14);
        send_frame(16'hA55A, CK_GOOD);
    endtask

    // ------------------------------------------------------------------
    // Driver: send one request per cycle from rx_stream, with random gaps.
    // Hold the byte while the block stalls; feed the model on acceptance.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid)
                parse_rx_byte(i_rx_byte);
            if (rx_stream.size() != 0 && $urandom_range(99) >= rx_gap_pct) begin
                i_valid   <= 1'b1;
                i_rx_byte <= rx_stream.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest expected frame,
    // then pick the stall for the next cycle.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_result due;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (frames_due.size() == 0) begin
                    flag_error("frame result with no frame pending");
                end else begin
                    due = frames_due.pop_front();
                    check_field("frame_status",   o_frame_status,   due.status);
                    check_field("accel_updated",  o_accel_updated,  due.accel_upd);
                    check_field("accel_x",        o_accel_x,        due.accel_x);
                    check_field("accel_y",        o_accel_y,        due.accel_y);
                    check_field("accel_z",        o_accel_z,        due.accel_z);
                    check_field("angles_updated", o_angles_updated, due.angles_upd);
                    check_field("pitch",          o_pitch,          due.pitch);
                    check_field("roll",           o_roll,           due.roll);
                    check_field("yaw",            o_yaw,            due.yaw);
                end
            end
            i_stall <= ($urandom_range(99) < res_hold_pct);
        end
    end

    // Watchdog: end the run if neither channel moves a request for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: reset, then three phases of gap and stall rates. Each phase fills the
    // stream and waits for every expected frame before moving on.
    // ------------------------------------------------------------------
    initial begin : sequencer
        int base;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    rx_gap_pct   = 33;
                    res_hold_pct = 70;
                end
                1: begin
                    rx_gap_pct   = 70;
                    res_hold_pct = 33;
                end
                default: begin
                    rx_gap_pct   = 0;
                    res_hold_pct = 0;
                end
            endcase
            if (ph == 0)
                send_directed_frames();
            base = rx_stream.size();
            while (rx_stream.size() < base + PHASE_BYTES)
                send_random_frame();
            while (rx_stream.size() != 0 || i_valid || frames_due.size() != 0)
                @(posedge i_clk);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (frames_due.size() != 0)
            flag_error($sformatf("%0d frame results never arrived", frames_due.size()));
        if (fault_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/imufp_pkg.sv
rtl/core/imufp_in_reg.sv
rtl/core/imufp_core.sv
rtl/core/imufp_out_reg.sv
rtl/core/imu_frame_parser_unit.sv
sim/imu_frame_parser_unit_tb.sv
